@@ rtl/rbc_pkg.sv @@
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types and constants for the ROM boot checksum block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbc_pkg;

  localparam logic [31:0] SEED_RESET     = 32'hF8CA4DDC;
  localparam logic        MIX_MODE_RESET = 1'b1;

  // Configuration register indexes.
  localparam logic [7:0] REG_SEED     = 8'd0;
  localparam logic [7:0] REG_MIX_MODE = 8'd1;

  // Boot mix selection.
  localparam logic MIX_ROTATE = 1'b0;
  localparam logic MIX_BOOT   = 1'b1;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Result queue at the output.
  localparam int OUT_DEPTH = 2;
  localparam int OUT_AW    = 1;

  typedef struct packed {
    logic [31:0] data_word;
    logic [31:0] boot_word;
    logic [31:0] rot_word;
    logic        first;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] crc1;
    logic [31:0] crc2;
  } result_t;

  typedef struct packed {
    logic [31:0] seed;
    logic        mix_mode;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

@@ rtl/rbc_front.sv @@
// ----------------------------------------------------------------------------
// rbc_front
// Input side: accepts words and precomputes the self-rotated word.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_front
  import rbc_pkg::*;
(
  input  wire logic        push,
  input  wire logic [31:0] data_word,
  input  wire logic [31:0] boot_word,
  input  wire logic        first,
  input  wire logic        last,
  input  wire q_status_t   q_status,
  output logic             full,
  output logic             q_wr,
  output item_t            q_item
);

  logic [63:0] dbl_shifted;

  // Rotating left by the low five bits is the upper half of the doubled word
  // shifted left; a zero amount leaves the word as it is.
  assign dbl_shifted = {data_word, data_word} << data_word[4:0];

  assign full = q_status.full;
  assign q_wr = push & ~q_status.full;

  always_comb begin
    q_item.data_word = data_word;
    q_item.boot_word = boot_word;
    q_item.rot_word  = dbl_shifted[63:32];
    q_item.first     = first;
    q_item.last      = last;
  end

endmodule

`default_nettype wire

@@ rtl/rbc_queue.sv @@
// ----------------------------------------------------------------------------
// rbc_queue
// Short item queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_queue
  import rbc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr,
  input  wire item_t wr_item,
  input  wire logic  rd,
  output item_t      rd_item,
  output q_status_t  status
);

  item_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign status.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_wr = wr & ~status.full;
  assign do_rd = rd & ~status.empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_AW+1)'(do_wr) - (Q_AW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rbc_back.sv @@
// ----------------------------------------------------------------------------
// rbc_back
// Accumulator datapath and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_back
  import rbc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire item_t q_item,
  input  wire logic  q_empty,
  output logic       q_rd,
  output logic       out_empty,
  input  wire logic  out_pop,
  output result_t    out_res
);

  logic [31:0] boot_mix_r, boot_mix_nxt;
  logic [31:0] cmp_xor_r, cmp_xor_nxt;
  logic [31:0] plain_xor_r, plain_xor_nxt;
  logic [31:0] carry_cnt_r, carry_cnt_nxt;
  logic [31:0] rot_sum_r, rot_sum_nxt;
  logic [31:0] sum_r, sum_nxt;

  logic [31:0] base_boot, base_cmp, base_plain, base_carry, base_rot, base_sum;
  logic [32:0] sum_wide;
  logic [31:0] d;

  result_t         res_mem_r [OUT_DEPTH];
  logic [OUT_AW-1:0] res_wr_ptr_r, res_wr_ptr_nxt;
  logic [OUT_AW-1:0] res_rd_ptr_r, res_rd_ptr_nxt;
  logic [OUT_AW:0]   res_cnt_r, res_cnt_nxt;
  logic              res_full, res_wr, res_rd;
  result_t           res_new;

  assign d = q_item.data_word;

  assign res_full  = (res_cnt_r == (OUT_AW+1)'(OUT_DEPTH));
  assign out_empty = (res_cnt_r == '0);
  assign res_rd    = out_pop & ~out_empty;

  // A closing word waits only while the result queue has no room.
  assign q_rd   = ~q_empty & (~q_item.last | ~res_full | res_rd);
  assign res_wr = q_rd & q_item.last;

  always_comb begin
    if (q_item.first) begin
      base_boot  = cfg.seed;
      base_cmp   = cfg.seed;
      base_plain = cfg.seed;
      base_carry = cfg.seed;
      base_rot   = cfg.seed;
      base_sum   = cfg.seed;
    end else begin
      base_boot  = boot_mix_r;
      base_cmp   = cmp_xor_r;
      base_plain = plain_xor_r;
      base_carry = carry_cnt_r;
      base_rot   = rot_sum_r;
      base_sum   = sum_r;
    end

    sum_wide      = {1'b0, base_sum} + {1'b0, d};
    sum_nxt       = sum_wide[31:0];
    carry_cnt_nxt = base_carry + {31'd0, sum_wide[32]};
    plain_xor_nxt = base_plain ^ d;
    rot_sum_nxt   = base_rot + q_item.rot_word;

    if (base_cmp > d) begin
      cmp_xor_nxt = base_cmp ^ q_item.rot_word;
    end else begin
      cmp_xor_nxt = base_cmp ^ sum_nxt ^ d;
    end

    if (cfg.mix_mode == MIX_BOOT) begin
      boot_mix_nxt = base_boot + (q_item.boot_word ^ d);
    end else begin
      boot_mix_nxt = base_boot + (rot_sum_nxt ^ d);
    end

    res_new.crc1 = sum_nxt ^ carry_cnt_nxt ^ plain_xor_nxt;
    res_new.crc2 = rot_sum_nxt ^ cmp_xor_nxt ^ boot_mix_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_mix_r  <= SEED_RESET;
      cmp_xor_r   <= SEED_RESET;
      plain_xor_r <= SEED_RESET;
      carry_cnt_r <= SEED_RESET;
      rot_sum_r   <= SEED_RESET;
      sum_r       <= SEED_RESET;
    end else if (q_rd) begin
      boot_mix_r  <= boot_mix_nxt;
      cmp_xor_r   <= cmp_xor_nxt;
      plain_xor_r <= plain_xor_nxt;
      carry_cnt_r <= carry_cnt_nxt;
      rot_sum_r   <= rot_sum_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // Result queue.
  assign out_res = res_mem_r[res_rd_ptr_r];

  always_comb begin
    res_wr_ptr_nxt = res_wr ? res_wr_ptr_r + 1'b1 : res_wr_ptr_r;
    res_rd_ptr_nxt = res_rd ? res_rd_ptr_r + 1'b1 : res_rd_ptr_r;
    res_cnt_nxt    = res_cnt_r + (OUT_AW+1)'(res_wr) - (OUT_AW+1)'(res_rd);
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_mem_r[res_wr_ptr_r] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_ptr_r <= '0;
      res_rd_ptr_r <= '0;
      res_cnt_r    <= '0;
    end else begin
      res_wr_ptr_r <= res_wr_ptr_nxt;
      res_rd_ptr_r <= res_rd_ptr_nxt;
      res_cnt_r    <= res_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rom_boot_checksum_top.sv @@
// ----------------------------------------------------------------------------
// rom_boot_checksum_top
// Streaming two-word boot checksum over 32-bit ROM words.
// ----------------------------------------------------------------------------
// The block takes one ROM word per clock and sustains that rate indefinitely
// as long as results are popped. A word enters a four-entry queue at the
// accepting edge, is then read out and folded into the six accumulators, and
// a closing word's checksums are written to the result queue by that same
// fold, from which they drive the result ports. The rate is set by the
// accumulator update in the back end; a two-entry result queue lets words
// keep flowing while a result waits to be popped.
// Configuration writes are always ready and should be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rom_boot_checksum_top
  import rbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [31:0] in_data_word,
  input  wire logic [31:0] in_boot_word,
  input  wire logic        in_first,
  input  wire logic        in_last,

  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [31:0]      out_crc1_out,
  output logic [31:0]      out_crc2_out,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_status;
  item_t     q_wr_item, q_rd_item;
  logic      q_wr, q_rd;
  result_t   res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SEED:     cfg_nxt.seed     = cfg_data;
        REG_MIX_MODE: cfg_nxt.mix_mode = cfg_data[0];
        default:      cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed     <= SEED_RESET;
      cfg_r.mix_mode <= MIX_MODE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rbc_front u_front (
    .push      (in_push),
    .data_word (in_data_word),
    .boot_word (in_boot_word),
    .first     (in_first),
    .last      (in_last),
    .q_status  (q_status),
    .full      (in_full),
    .q_wr      (q_wr),
    .q_item    (q_wr_item)
  );

  rbc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_item (q_wr_item),
    .rd      (q_rd),
    .rd_item (q_rd_item),
    .status  (q_status)
  );

  rbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_item    (q_rd_item),
    .q_empty   (q_status.empty),
    .q_rd      (q_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  assign out_crc1_out = res.crc1;
  assign out_crc2_out = res.crc2;

endmodule

`default_nettype wire

@@ rtl/rbc_checker.sv @@
// ----------------------------------------------------------------------------
// rbc_checker
// Port-level checks for the ROM boot checksum block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        in_last,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [31:0] out_crc1_out,
  input wire logic [31:0] out_crc2_out
);

  logic [3:0] pend_r, pend_nxt;
  logic       last_in, res_out;

  // Closing words accepted whose result has not yet been popped.
  assign last_in  = in_push & ~in_full & in_last;
  assign res_out  = out_pop & ~out_empty;
  assign pend_nxt = pend_r + {3'd0, last_in} - {3'd0, res_out};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (!in_full && out_empty))
    else $error("block not idle after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_crc1_out) && $stable(out_crc2_out)))
    else $error("waiting result changed or vanished");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (pend_r != 4'd0))
    else $error("result shown without a closing item");

  // With no closing word ahead, only plain words can sit in the input queue,
  // and they drain one per cycle, so the result follows without waiting for a pop.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (last_in && out_empty && pend_r == 4'd0) |-> ##[2:4] !out_empty)
    else $error("result late for a closing item");

endmodule

bind rom_boot_checksum_top rbc_checker u_rbc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_push      (in_push),
  .in_full      (in_full),
  .in_last      (in_last),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_crc1_out (out_crc1_out),
  .out_crc2_out (out_crc2_out)
);

`default_nettype wire

@@ tb/tb_rom_boot_checksum_top.sv @@
// ----------------------------------------------------------------------------
// tb_rom_boot_checksum_top
// Self-checking testbench for the streaming ROM boot checksum block.
// ----------------------------------------------------------------------------
// ROM words are queued by a stimulus process and pushed by a clocked driver.
// Every accepted word is folded into a local copy of the six accumulators,
// and a closing word queues the pair of checksums it should produce. A
// clocked monitor takes popped results and compares both checksums with the oldest
// expected pair. Directed words cover wraps, rotate by zero, both compare
// branches, both boot mix modes, ignored register writes and a seed change
// in the middle of a run. Random phases follow under several seed and mode
// settings, with random stalls on both sides and a long result stall that
// backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rom_boot_checksum_top;
  import rbc_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int POP_HOLD_CYCLES = 80;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic [31:0] data;
    logic [31:0] boot;
    logic        first;
    logic        last;
  } rom_word_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_push      = 1'b0;
  logic        in_full;
  logic [31:0] in_data_word = '0;
  logic [31:0] in_boot_word = '0;
  logic        in_first     = 1'b0;
  logic        in_last      = 1'b0;
  logic        out_empty;
  logic        out_pop      = 1'b0;
  logic [31:0] out_crc1_out;
  logic [31:0] out_crc2_out;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index    = '0;
  logic [31:0] cfg_data     = '0;

  rom_boot_checksum_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_word (in_data_word),
    .in_boot_word (in_boot_word),
    .in_first     (in_first),
    .in_last      (in_last),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_crc1_out (out_crc1_out),
    .out_crc2_out (out_crc2_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Local copy of the configuration and the accumulators.
  logic [31:0] seed_reg  = SEED_RESET;
  logic        mix_reg   = MIX_MODE_RESET;
  logic [31:0] sum_acc   = SEED_RESET;
  logic [31:0] carry_acc = SEED_RESET;
  logic [31:0] xor_acc   = SEED_RESET;
  logic [31:0] rot_acc   = SEED_RESET;
  logic [31:0] cmp_acc   = SEED_RESET;
  logic [31:0] mix_acc   = SEED_RESET;

  rom_word_t word_q[$];
  result_t   crc_expect_q[$];

  int fail_count    = 0;
  int quiet_cycles  = 0;
  int push_gap      = 0;
  int pop_gap       = 0;
  int hold_left     = 0;
  int hold_requests = 0;
  int holds_begun   = 0;
  bit steady        = 1'b0;

  task automatic fold_word(input rom_word_t w);
    logic [31:0] new_sum;
    logic [63:0] spun;
    logic [31:0] rot;
    result_t     crc;
    if (w.first) begin
      sum_acc   = seed_reg;
      carry_acc = seed_reg;
      xor_acc   = seed_reg;
      rot_acc   = seed_reg;
      cmp_acc   = seed_reg;
      mix_acc   = seed_reg;
    end
    new_sum = sum_acc + w.data;
    if (new_sum < sum_acc) begin
      carry_acc = carry_acc + 32'd1;
    end
    sum_acc = new_sum;
    xor_acc = xor_acc ^ w.data;
    // The upper half of the doubled word shifted left is the left rotation.
    spun    = {w.data, w.data} << w.data[4:0];
    rot     = spun[63:32];
    rot_acc = rot_acc + rot;
    if (cmp_acc > w.data) begin
      cmp_acc = cmp_acc ^ rot;
    end else begin
      cmp_acc = cmp_acc ^ sum_acc ^ w.data;
    end
    if (mix_reg == MIX_BOOT) begin
      mix_acc = mix_acc + (w.boot ^ w.data);
    end else begin
      mix_acc = mix_acc + (rot_acc ^ w.data);
    end
    if (w.last) begin
      crc.crc1 = sum_acc ^ carry_acc ^ xor_acc;
      crc.crc2 = rot_acc ^ cmp_acc ^ mix_acc;
      crc_expect_q.push_back(crc);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %08h, got %08h", what, want, got);
    end
  endtask

  // Input driver: offers the oldest pending word, with random idle bursts.
  always @(negedge clk) begin
    if (!rst_n || word_q.size() == 0) begin
      in_push <= 1'b0;
    end else if (push_gap > 0) begin
      in_push <= 1'b0;
      push_gap--;
    end else if (!steady && $urandom_range(0, 19) == 0) begin
      in_push <= 1'b0;
      push_gap = $urandom_range(1, 10) - 1;
    end else begin
      in_push      <= 1'b1;
      in_data_word <= word_q[0].data;
      in_boot_word <= word_q[0].boot;
      in_first     <= word_q[0].first;
      in_last      <= word_q[0].last;
    end
  end

  // Result side: random pop stalls, plus a long hold when one is requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left--;
    end else if (holds_begun < hold_requests) begin
      out_pop <= 1'b0;
      holds_begun++;
      hold_left = POP_HOLD_CYCLES - 1;
    end else if (pop_gap > 0) begin
      out_pop <= 1'b0;
      pop_gap--;
    end else if (!steady && $urandom_range(0, 19) == 0) begin
      out_pop <= 1'b0;
      pop_gap = $urandom_range(1, 10) - 1;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Monitor: folds accepted words and checks popped results.
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_push && !in_full) begin
        fold_word(word_q.pop_front());
      end
      if (out_pop && !out_empty) begin
        if (crc_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("result %08h %08h popped with none expected",
                     out_crc1_out, out_crc2_out);
          end
        end else begin
          want = crc_expect_q.pop_front();
          if (out_crc1_out !== want.crc1) begin
            report_mismatch("crc1_out", want.crc1, out_crc1_out);
          end
          if (out_crc2_out !== want.crc2) begin
            report_mismatch("crc2_out", want.crc2, out_crc2_out);
          end
        end
      end
    end
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** rom_boot_checksum_top: FAILED **");
    $finish;
  end

  task automatic queue_word(input logic [31:0] data, input logic [31:0] boot,
                            input logic first, input logic last);
    rom_word_t w;
    w.data  = data;
    w.boot  = boot;
    w.first = first;
    w.last  = last;
    word_q.push_back(w);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 31);
      3:       return $urandom & 32'hFFFF_FFE0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed runs with random content, with some stray words that
  // carry random first and last marks.
  task automatic queue_words(input int count);
    int added;
    int len;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_word(rand_word(), $urandom, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        added++;
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          queue_word(rand_word(), $urandom, i == 0, i == len - 1);
        end
        added += len;
      end
    end
  endtask

  // Waits for every word and result, then lets trailing words settle.
  task automatic wait_idle();
    while (word_q.size() != 0 || crc_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_SEED:     seed_reg = value;
      REG_MIX_MODE: mix_reg  = value[0];
      default:      ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Words ahead of any first fold into the reset values.
    queue_word(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    queue_word(32'h8000_0000, 32'h1234_5678, 1'b1, 1'b1);
    queue_word(32'h0000_001F, 32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
    queue_word(32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0, 1'b0);
    queue_word(32'h0000_0001, 32'h5A5A_5A5A, 1'b0, 1'b0);
    queue_word(32'h7FFF_FFE0, 32'h0000_0000, 1'b0, 1'b1);
    wait_idle();

    // A zero seed makes the first compare take the sum branch.
    write_reg(REG_MIX_MODE, {31'h0, MIX_ROTATE});
    write_reg(REG_SEED, 32'h0000_0000);
    queue_word(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_word(32'hFFFF_FFFF, 32'h0F0F_0F0F, 1'b0, 1'b0);
    queue_word(32'h0000_0010, 32'hF0F0_F0F0, 1'b0, 1'b0);
    queue_word(32'hDEAD_BEEF, 32'h0000_0000, 1'b0, 1'b1);
    wait_idle();

    // Writes to unknown indexes are dropped, and mix_mode keeps only bit 0.
    write_reg(REG_SEED, 32'hFFFF_FFFF);
    write_reg(8'd2, 32'h0000_0000);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    write_reg(REG_MIX_MODE, 32'hFFFF_FFFE);
    queue_word(32'h0000_0000, 32'h1111_1111, 1'b1, 1'b0);
    queue_word(32'h0000_0001, 32'h2222_2222, 1'b0, 1'b0);
    queue_word(32'hFFFF_FFFE, 32'h3333_3333, 1'b0, 1'b1);
    queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    wait_idle();
    write_reg(REG_MIX_MODE, 32'h8000_0001);
    queue_word(32'h0000_0020, 32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        write_reg(REG_SEED, 32'h0000_0000);
        write_reg(REG_MIX_MODE, $urandom & 32'hFFFF_FFFE);
      end else if (p == 1) begin
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        write_reg(REG_MIX_MODE, $urandom | 32'h0000_0001);
      end else begin
        write_reg(REG_SEED, $urandom);
        write_reg(REG_MIX_MODE, $urandom);
        write_reg(8'($urandom_range(2, 255)), $urandom);
      end
      if (p == 2) begin
        // Results pile up behind a long pop stall until the block pushes back.
        hold_requests++;
        repeat (24) queue_word(rand_word(), $urandom, 1'b1, 1'b1);
      end
      if (p == 3) begin
        // A seed written in the middle of a run waits for the next first word.
        queue_word(rand_word(), $urandom, 1'b1, 1'b0);
        repeat (3) queue_word(rand_word(), $urandom, 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_SEED, $urandom);
        repeat (2) queue_word(rand_word(), $urandom, 1'b0, 1'b0);
        queue_word(rand_word(), $urandom, 1'b0, 1'b1);
        queue_word(rand_word(), $urandom, 1'b1, 1'b1);
      end
      queue_words(150);
      wait_idle();
    end

    steady = 1'b1;
    queue_words(100);
    wait_idle();
    repeat (10) @(posedge clk);

    if (fail_count == 0 && crc_expect_q.size() == 0) begin
      $display("** rom_boot_checksum_top: PASSED **");
    end else begin
      $display("** rom_boot_checksum_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
